FILE: hdl/spte_pkg.sv
package spte_pkg;

    localparam int MAX_TERMS    = 64;
    localparam int MAX_EXPONENT = 9;
    localparam int IDX_W        = $clog2(MAX_TERMS);
    localparam int CNT_W        = 7;
    localparam int COEF_W       = 32;
    localparam int CODE_W       = 12;
    localparam int ENTRY_W      = COEF_W + CODE_W;
    localparam int ACC_W        = 40;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_EVAL   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // datapath operand select for the shared multiplier
    localparam logic [1:0] OP_X    = 2'd0;
    localparam logic [1:0] OP_Y    = 2'd1;
    localparam logic [1:0] OP_Z    = 2'd2;
    localparam logic [1:0] OP_COEF = 2'd3;

    // table write data select
    localparam logic [1:0] WR_NEW  = 2'd0;
    localparam logic [1:0] WR_FOLD = 2'd1;
    localparam logic [1:0] WR_MOVE = 2'd2;

    typedef struct packed {
        logic             load;      // capture input item
        logic             clr_cnt;   // empty the table
        logic             rd;        // read entry at rd_idx
        logic [IDX_W-1:0] rd_idx;
        logic             wr;        // write wr_data at wr_idx
        logic [IDX_W-1:0] wr_idx;
        logic [1:0]       wr_sel;    // new term, folded term or moved entry
        logic             cnt_inc;
        logic             cnt_dec;
        logic             term_init; // t = 1.0 from entry just read
        logic             mul;       // one multiply step
        logic [1:0]       mul_op;
        logic             acc_add;
        logic             acc_clr;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CODE_W-1:0] in_code;
        logic [CODE_W-1:0] rd_code;
        logic [3:0]        exp_x;
        logic [3:0]        exp_y;
        logic [3:0]        exp_z;
        logic              in_coef_zero;
        logic              fold_zero;
    } t_stat;

    function automatic logic [3:0] clamp_nib(input logic [3:0] n);
        return (n > 4'(MAX_EXPONENT)) ? 4'(MAX_EXPONENT) : n;
    endfunction

endpackage

FILE: hdl/spte_datapath.sv
module spte_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spte_pkg::t_cmd       i_cmd,
    output spte_pkg::t_stat      o_stat,
    input  logic signed [31:0]   i_coefficient,
    input  logic [11:0]          i_exponents,
    input  logic signed [31:0]   i_point_x,
    input  logic signed [31:0]   i_point_y,
    input  logic signed [31:0]   i_point_z,
    output logic signed [31:0]   o_sum,
    output logic                 o_sat
);
    import spte_pkg::*;

    logic [ENTRY_W-1:0] r_mem [MAX_TERMS];
    logic [ENTRY_W-1:0] r_rd;
    logic signed [31:0] r_coef, r_px, r_py, r_pz;
    logic [CODE_W-1:0]  r_code;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [31:0] r_t;
    logic signed [ACC_W-1:0] r_acc;
    logic               r_sat;
    logic signed [31:0] fold;
    logic signed [32:0] fold_w;
    logic signed [31:0] rd_coef;
    logic signed [31:0] mop;
    logic signed [63:0] prod;
    logic signed [47:0] q;
    logic [ENTRY_W-1:0] wdata;

    assign rd_coef = r_rd[ENTRY_W-1:CODE_W];
    assign fold_w  = 33'(rd_coef) + 33'(r_coef);
    always_comb begin
        if (fold_w > 33'sh07FFFFFFF) fold = 32'sh7FFFFFFF;
        else if (fold_w < -33'sh080000000) fold = 32'sh80000000;
        else fold = fold_w[31:0];
    end

    // a moved entry is the one read in the cycle before
    always_comb begin
        case (i_cmd.wr_sel)
            WR_NEW:  wdata = {r_coef, r_code};
            WR_FOLD: wdata = {fold, r_code};
            default: wdata = r_rd;
        endcase
    end

    always_comb begin
        case (i_cmd.mul_op)
            OP_X:    mop = r_px;
            OP_Y:    mop = r_py;
            OP_Z:    mop = r_pz;
            default: mop = rd_coef;
        endcase
    end
    assign prod = 64'(r_t) * 64'(mop);
    assign q    = 48'((prod + 64'sd32768) >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= r_mem[i_cmd.rd_idx];
        if (i_cmd.wr) r_mem[i_cmd.wr_idx] <= wdata;
        if (i_cmd.load) begin
            r_coef <= i_coefficient;
            r_code <= {clamp_nib(i_exponents[11:8]), clamp_nib(i_exponents[7:4]),
                       clamp_nib(i_exponents[3:0])};
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
        end
        if (i_cmd.term_init) r_t <= 32'sh00010000;
        else if (i_cmd.mul) begin
            if (q > 48'sh7FFFFFFF) r_t <= 32'sh7FFFFFFF;
            else if (q < -48'sh80000000) r_t <= 32'sh80000000;
            else r_t <= q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_acc <= '0;
            r_sat <= 1'b0;
        end else begin
            if (i_cmd.clr_cnt) r_cnt <= '0;
            else if (i_cmd.cnt_inc) r_cnt <= r_cnt + 1'b1;
            else if (i_cmd.cnt_dec) r_cnt <= r_cnt - 1'b1;
            if (i_cmd.acc_clr) begin
                r_acc <= '0;
                r_sat <= 1'b0;
            end else begin
                if (i_cmd.acc_add) r_acc <= r_acc + ACC_W'(r_t);
                if (i_cmd.mul && (q > 48'sh7FFFFFFF || q < -48'sh80000000)) r_sat <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_acc > 40'sh007FFFFFFF) o_sum = 32'sh7FFFFFFF;
        else if (r_acc < -40'sh0080000000) o_sum = 32'sh80000000;
        else o_sum = r_acc[31:0];
    end
    assign o_sat = r_sat || (r_acc > 40'sh007FFFFFFF) || (r_acc < -40'sh0080000000);

    assign o_stat.count        = r_cnt;
    assign o_stat.in_code      = r_code;
    assign o_stat.rd_code      = r_rd[CODE_W-1:0];
    assign o_stat.exp_x        = r_rd[11:8];
    assign o_stat.exp_y        = r_rd[7:4];
    assign o_stat.exp_z        = r_rd[3:0];
    assign o_stat.in_coef_zero = (r_coef == 32'sd0);
    assign o_stat.fold_zero    = (fold == 32'sd0);

endmodule

FILE: hdl/spte_ctrl.sv
module spte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_mode,
    output logic            busy,
    output spte_pkg::t_cmd  o_cmd,
    input  spte_pkg::t_stat i_stat,
    input  logic            i_sat,
    output logic            o_done,
    output logic            o_is_eval,
    output logic [1:0]      o_status
);
    import spte_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SRD     = 4'd1;  // read entry i
    localparam logic [3:0] S_SCMP    = 4'd2;  // compare with code
    localparam logic [3:0] S_DEL_RD  = 4'd3;  // read i+1 for shift down
    localparam logic [3:0] S_DEL_WR  = 4'd4;
    localparam logic [3:0] S_INS_RD  = 4'd5;  // read j-1 for shift up
    localparam logic [3:0] S_INS_WR  = 4'd6;
    localparam logic [3:0] S_ERD     = 4'd7;
    localparam logic [3:0] S_EINIT   = 4'd8;
    localparam logic [3:0] S_EMUL    = 4'd9;
    localparam logic [3:0] S_EADD    = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;
    localparam logic [3:0] S_INS_NEW = 4'd12; // new term into the hole at 0

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_i, n_i;
    logic [1:0]       r_mode, n_mode;
    logic [1:0]       r_st, n_st;
    logic [1:0]       r_op, n_op;
    logic [3:0]       r_k, n_k;
    logic [CNT_W-1:0] cnt;

    assign cnt = i_stat.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_mode  <= MODE_INSERT;
            r_st    <= ST_OK;
            r_op    <= OP_X;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_mode  <= n_mode;
            r_st    <= n_st;
            r_op    <= n_op;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_mode  = r_mode;
        n_st    = r_st;
        n_op    = r_op;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.rd_idx = r_i[IDX_W-1:0];
        o_cmd.wr_idx = r_i[IDX_W-1:0];
        o_cmd.mul_op = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_mode = i_mode;
                    n_st   = ST_OK;
                    n_i    = '0;
                    if (i_mode == MODE_INSERT) n_state = S_SRD;
                    else if (i_mode == MODE_EVAL) begin
                        o_cmd.acc_clr = 1'b1;
                        n_state = S_ERD;
                    end else begin
                        if (i_mode == MODE_CLEAR) o_cmd.clr_cnt = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_SRD: begin
                if (r_i >= cnt) begin
                    // append or fall past the end
                    if (i_stat.in_coef_zero) n_state = S_DONE;
                    else if (cnt >= CNT_W'(MAX_TERMS)) begin
                        n_st = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.wr = 1'b1;
                        o_cmd.wr_sel = WR_NEW;
                        o_cmd.cnt_inc = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_stat.rd_code < i_stat.in_code) begin
                    n_i = r_i + 1'b1;
                    n_state = S_SRD;
                end else if (i_stat.rd_code == i_stat.in_code) begin
                    if (i_stat.fold_zero) n_state = S_DEL_RD;
                    else begin
                        o_cmd.wr = 1'b1;
                        o_cmd.wr_sel = WR_FOLD;
                        n_state = S_DONE;
                    end
                end else if (i_stat.in_coef_zero) n_state = S_DONE;
                else if (cnt >= CNT_W'(MAX_TERMS)) begin
                    n_st = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    // shift entries i..cnt-1 up by one, from the top
                    n_i = cnt;
                    n_state = S_INS_RD;
                end
            end
            S_DEL_RD: begin
                if (r_i + 1'b1 >= cnt) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_idx = IDX_W'(r_i + 1'b1);
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                n_state = S_DEL_RD;
                n_i = r_i + 1'b1;
                o_cmd.wr = 1'b1;
                o_cmd.wr_sel = WR_MOVE;
            end
            S_INS_RD: begin
                o_cmd.rd = 1'b1;
                o_cmd.rd_idx = IDX_W'(r_i - 1'b1);
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                if (i_stat.rd_code > i_stat.in_code) begin
                    o_cmd.wr = 1'b1;
                    o_cmd.wr_sel = WR_MOVE;
                    n_i = r_i - 1'b1;
                    n_state = (r_i == CNT_W'(1)) ? S_INS_NEW : S_INS_RD;
                end else begin
                    // entry below is smaller: the hole at r_i takes the new term
                    o_cmd.wr = 1'b1;
                    o_cmd.wr_sel = WR_NEW;
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_INS_NEW: begin
                o_cmd.wr = 1'b1;
                o_cmd.wr_sel = WR_NEW;
                o_cmd.cnt_inc = 1'b1;
                n_state = S_DONE;
            end
            S_ERD: begin
                if (r_i >= cnt) n_state = S_DONE;
                else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_EINIT;
                end
            end
            S_EINIT: begin
                o_cmd.term_init = 1'b1;
                n_op = OP_X;
                n_k  = i_stat.exp_x;
                n_state = S_EMUL;
            end
            S_EMUL: begin
                if (r_op != OP_COEF && r_k == '0) begin
                    n_op = r_op + 1'b1;
                    n_k  = (r_op == OP_X) ? i_stat.exp_y : i_stat.exp_z;
                end else begin
                    o_cmd.mul = 1'b1;
                    if (r_op == OP_COEF) n_state = S_EADD;
                    else n_k = r_k - 1'b1;
                end
            end
            S_EADD: begin
                o_cmd.acc_add = 1'b1;
                n_i = r_i + 1'b1;
                n_state = S_ERD;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy      = (r_state != S_IDLE);
    assign o_done    = (r_state == S_DONE);
    assign o_is_eval = (r_mode == MODE_EVAL);
    assign o_status  = (r_mode == MODE_EVAL) ? (i_sat ? ST_SAT : ST_OK) : r_st;

endmodule

FILE: hdl/sparse_poly_term_table_eval.sv
// Sparse polynomial term table in x, y, z with evaluation.
// Command channel: drive i_mode and the payload with start high; the item is
// taken at the edge where start is high and busy is low. Payload is sampled
// only at that edge.
//   insert (0): fold coefficient into the term of equal exponents, or open a
//               sorted slot; a zero result removes the term. Status 1 if the
//               table is full.
//   evaluate (1): sum of coef*x^a*y^b*z^c in Q16.16, saturating, status 2 on saturation.
//   clear (2): empties the table.
// Result: o_valid pulses for one cycle with o_value, o_term_count, o_status.
// The receiver cannot stall; the result must be taken in that cycle.
// Insert scans entries in order, then shifts entries down to remove a term
// or up to open a sorted slot. Evaluate multiplies each term out one factor
// at a time, one step per exponent unit plus one for the coefficient, bound
// by the single shared multiplier.
// One item at a time.
// Reset clears the term count and controller; table contents need no
// clearing pass.
module sparse_poly_term_table_eval (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_coefficient,
    input  logic [11:0]        i_exponents,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_valid,
    output logic signed [31:0] o_value,
    output logic [6:0]         o_term_count,
    output logic [1:0]         o_status
);
    import spte_pkg::*;

    t_cmd               cmd;
    t_stat              stat;
    logic signed [31:0] sum;
    logic               sat, done, is_eval;
    logic [1:0]         st;

    spte_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .i_mode, .busy,
        .o_cmd(cmd), .i_stat(stat), .i_sat(sat),
        .o_done(done), .o_is_eval(is_eval), .o_status(st)
    );

    spte_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_coefficient, .i_exponents, .i_point_x, .i_point_y, .i_point_z,
        .o_sum(sum), .o_sat(sat)
    );

    assign o_valid      = done;
    assign o_value      = is_eval ? sum : 32'sd0;
    assign o_term_count = stat.count;
    assign o_status     = st;

endmodule

FILE: hdl/spte_checker.sv
module spte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [6:0] o_term_count,
    input logic [1:0] o_status
);
    a_no_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result without item");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_term_count <= 7'd64) else $error("count overflow");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
endmodule

bind sparse_poly_term_table_eval spte_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_term_count, .o_status
);
